>>> hdl/m3h_pkg.sv
// Package for the MurmurHash3 x86_32 byte stream hasher.
// Holds the hash constants, the sequencer state type and the multiplier control type.
// Depends on nothing; m3h_mul and the top level import it.
package m3h_pkg;

	localparam logic [31:0] SEED_RESET = 32'd123456;
	localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2      = 32'h1b873593;
	localparam logic [31:0] MM_ADD     = 32'he6546b64;
	localparam logic [31:0] MM_F1      = 32'h85ebca6b;
	localparam logic [31:0] MM_F2      = 32'hc2b2ae35;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4
	} state_t;

	typedef enum logic [1:0] {
		MOP_C1,
		MOP_C2,
		MOP_F1,
		MOP_F2
	} mul_op_t;

	typedef struct packed {
		logic    en;
		mul_op_t op;
	} mul_ctl_t;

	function automatic logic [31:0] mul_const(input mul_op_t op);
		logic [31:0] k;
		unique case (op)
			MOP_C1:  k = MM_C1;
			MOP_C2:  k = MM_C2;
			MOP_F1:  k = MM_F1;
			MOP_F2:  k = MM_F2;
			default: k = MM_C1;
		endcase
		return k;
	endfunction

endpackage

>>> hdl/m3h_ifs.sv
// Channel interfaces of the MurmurHash3 byte stream hasher.
// Key byte input, hash result output and seed write channel, each with valid and ready.
// Depends on nothing.
interface m3h_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;

	modport source (output valid, data_byte, byte_valid, last, input ready);
	modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface m3h_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

interface m3h_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed;

	modport source (output valid, seed, input ready);
	modport sink (input valid, seed, output ready);
endinterface

>>> hdl/m3h_mul.sv
// Shared 32x32 multiplier with a registered low product word.
// Multiplies the given operand by one of the four hash constants.
// Depends on m3h_pkg.
module m3h_mul
	import m3h_pkg::*;
(
	input  logic        clk,
	input  mul_ctl_t    ctl,
	input  logic [31:0] operand,
	output logic [31:0] product_q
);

	logic [31:0] product;

	assign product = operand * mul_const(ctl.op);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			product_q <= product;
		end
	end

endmodule

>>> hdl/murmur3_byte_stream_hasher.sv
// Top level of the MurmurHash3 x86_32 byte stream hasher.
// Gathers key bytes into words and runs scramble, mix and finalizer on one shared multiplier.
// Depends on m3h_pkg, the interfaces in m3h_ifs.sv and m3h_mul.
//
//   channel   dir   payload                          transaction
//   byte_ch   in    data_byte, byte_valid, last      valid && ready
//   hash_ch   out   hash_value                       valid && ready
//   cfg_ch    in    seed                             valid && ready (ready is always high)
//
// A byte that does not complete a word is taken in idle; one that completes a word then runs
// the scramble (ST_K1, ST_K2) and mix (ST_K3). A last item runs the finalizer ST_F0 to ST_F4
// after any tail scramble or word path; the four multiplications share the single multiplier.
// Reset loads the seed register and the running hash with 123456 and clears the byte state.
// The block waits in its last finalizer step while a previous hash has not been taken.
module murmur3_byte_stream_hasher
	import m3h_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	m3h_byte_if.sink   byte_ch,
	m3h_hash_if.source hash_ch,
	m3h_cfg_if.sink    cfg_ch
);

	state_t      state_q;
	state_t      state_d;
	logic [31:0] seed_q;
	logic [31:0] acc_q;
	logic [31:0] word_q;
	logic [1:0]  pos_q;
	logic [31:0] len_q;
	logic        fin_q;
	logic        tail_q;
	logic [31:0] h_q;
	logic [31:0] hash_q;
	logic        out_valid_q;

	mul_ctl_t    mctl;
	logic [31:0] mul_opnd;
	logic [31:0] k_q;

	logic        take;
	logic        done;
	logic [1:0]  pos_next;
	logic        word_done;
	logic [31:0] mix_rot;
	logic [31:0] fin_x;

	assign cfg_ch.ready       = 1'b1;
	assign hash_ch.valid      = out_valid_q;
	assign hash_ch.hash_value = hash_q;

	assign take      = byte_ch.valid && byte_ch.ready;
	assign pos_next  = byte_ch.byte_valid ? pos_q + 2'd1 : pos_q;
	assign word_done = byte_ch.byte_valid && (pos_q == 2'd3);
	assign mix_rot   = {acc_q[18:0] ^ k_q[18:0], acc_q[31:19] ^ k_q[31:19]};
	assign fin_x     = acc_q ^ len_q ^ (tail_q ? k_q : 32'd0);

	m3h_mul u_mul (
		.clk       (clk),
		.ctl       (mctl),
		.operand   (mul_opnd),
		.product_q (k_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mctl          = '{en: 1'b0, op: MOP_C1};
		mul_opnd      = word_q;
		byte_ch.ready = 1'b0;
		done          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				byte_ch.ready = 1'b1;
				if (take) begin
					if (word_done || (byte_ch.last && pos_next != 2'd0)) begin
						state_d = ST_K1;
					end else if (byte_ch.last) begin
						state_d = ST_F0;
					end
				end
			end
			ST_K1: begin
				mctl     = '{en: 1'b1, op: MOP_C1};
				mul_opnd = word_q;
				state_d  = ST_K2;
			end
			ST_K2: begin
				mctl     = '{en: 1'b1, op: MOP_C2};
				mul_opnd = {k_q[16:0], k_q[31:17]};
				state_d  = tail_q ? ST_F0 : ST_K3;
			end
			ST_K3: begin
				state_d = fin_q ? ST_F0 : ST_IDLE;
			end
			ST_F0: begin
				state_d = ST_F1;
			end
			ST_F1: begin
				mctl     = '{en: 1'b1, op: MOP_F1};
				mul_opnd = h_q;
				state_d  = ST_F2;
			end
			ST_F2: begin
				state_d = ST_F3;
			end
			ST_F3: begin
				mctl     = '{en: 1'b1, op: MOP_F2};
				mul_opnd = h_q;
				state_d  = ST_F4;
			end
			ST_F4: begin
				if (!out_valid_q || hash_ch.ready) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			acc_q       <= SEED_RESET;
			word_q      <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			fin_q       <= 1'b0;
			tail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				seed_q <= cfg_ch.seed;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (hash_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (byte_ch.byte_valid) begin
							word_q <= word_q | (32'(byte_ch.data_byte) << {pos_q, 3'b000});
							pos_q  <= pos_next;
							len_q  <= len_q + 32'd1;
						end
						fin_q  <= byte_ch.last;
						tail_q <= byte_ch.last && (pos_next != 2'd0);
					end
				end
				ST_K3: begin
					acc_q  <= {mix_rot[29:0], 2'b00} + mix_rot + MM_ADD;
					word_q <= '0;
				end
				ST_F4: begin
					if (done) begin
						acc_q  <= seed_q;
						word_q <= '0;
						pos_q  <= '0;
						len_q  <= '0;
						fin_q  <= 1'b0;
						tail_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_F0) begin
			h_q <= fin_x ^ (fin_x >> 16);
		end else if (state_q == ST_F2) begin
			h_q <= k_q ^ (k_q >> 13);
		end
		if (done) begin
			hash_q <= k_q ^ (k_q >> 16);
		end
	end

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !fin_q && !tail_q)
		else $error("Key end flags left set in idle.");

	a_tail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K2 && tail_q) |-> pos_q != 2'd0)
		else $error("Tail scramble without buffered bytes.");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> acc_q == $past(seed_q) && len_q == 32'd0 && pos_q == 2'd0)
		else $error("Key state not restarted from the seed.");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_ch.byte_valid) |=> len_q == $past(len_q) + 32'd1)
		else $error("Byte count did not advance on a key byte.");
`endif

endmodule
